/* rtl/fkin_pkg.sv */
// ----------------------------------------------------------------------------
// fkin_pkg
// Shared types, constants and arithmetic helpers for the six-joint
// forward kinematics core.
// ----------------------------------------------------------------------------
package fkin_pkg;

   localparam int AngW        = 16;
   localparam int TrigW       = 18;
   localparam int CfgW        = 18;
   localparam int PosW        = 21;
   localparam int AccPW       = 23;   // running position, wide enough for five links
   localparam int LinkPW      = 19;   // link translation, holds a negated register
   localparam int NumJoints   = 6;
   localparam int CordicSteps = 16;
   localparam int XyW         = 34;
   localparam int ZW          = 33;
   localparam int ProdW       = 36;
   localparam int PProdW      = 37;
   localparam int SumW        = 38;
   localparam int CsrIdxW     = 3;
   localparam int MidDepth    = 4;
   localparam int OutDepth    = 4;

   localparam logic [17:0]            PhaseScale = 18'd166886;
   localparam logic signed [XyW-1:0]  CordicX0   = 34'sd652032874;
   localparam logic signed [TrigW-1:0] OneQ16    = 18'sd65536;

   localparam logic [31:0] AtanTurns [CordicSteps] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };

   typedef enum logic [CsrIdxW-1:0] {
      REG_BASE_HEIGHT      = 3'd0,
      REG_UPPER_ARM_LENGTH = 3'd1,
      REG_FOREARM_LENGTH   = 3'd2,
      REG_THIRD_OFFSET     = 3'd3,
      REG_FOURTH_OFFSET    = 3'd4,
      REG_FIFTH_OFFSET     = 3'd5,
      REG_SIXTH_OFFSET     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      TWIST_NONE,
      TWIST_NEG,
      TWIST_LAST
   } twist_type;

   typedef struct packed {
      logic signed [TrigW-1:0] c;
      logic signed [TrigW-1:0] s;
   } trig_type;

   typedef trig_type [NumJoints-1:0] joint_trig_type;
   typedef logic [NumJoints-1:0][AngW-1:0] joint_angle_type;

   typedef struct packed {
      logic [8:0][TrigW-1:0] r;
      logic [2:0][AccPW-1:0] p;
   } pose_type;

   typedef struct packed {
      logic [8:0][TrigW-1:0]  r;
      logic [2:0][LinkPW-1:0] p;
   } link_type;

   typedef struct packed {
      logic signed [CfgW-1:0] base_height;
      logic signed [CfgW-1:0] upper_arm_length;
      logic signed [CfgW-1:0] forearm_length;
      logic signed [CfgW-1:0] third_offset;
      logic signed [CfgW-1:0] fourth_offset;
      logic signed [CfgW-1:0] fifth_offset;
      logic signed [CfgW-1:0] sixth_offset;
   } cfg_type;

   typedef struct packed {
      logic [2:0][PosW-1:0]  pos;
      logic [8:0][TrigW-1:0] rot;
   } result_type;

   // round Q3.30 to Q1.16, clamp to +-1, optional negate
   function automatic logic signed [TrigW-1:0] trig_round(logic signed [XyW-1:0] v,
                                                          logic flip);
      logic signed [XyW-1:0]   t;
      logic signed [TrigW-1:0] r;
      t = (v + 34'sd8192) >>> 14;
      if (t > 34'sd65536) begin
         r = OneQ16;
      end else if (t < -34'sd65536) begin
         r = -OneQ16;
      end else begin
         r = t[TrigW-1:0];
      end
      return flip ? -r : r;
   endfunction

   function automatic logic signed [TrigW-1:0] rot_round(logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] t;
      t = (v + 38'sd32768) >>> 16;
      if (t > 38'sd65536) begin
         return OneQ16;
      end else if (t < -38'sd65536) begin
         return -OneQ16;
      end
      return t[TrigW-1:0];
   endfunction

   function automatic logic signed [AccPW-1:0] pos_round(logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] t;
      t = (v + 38'sd32768) >>> 16;
      return t[AccPW-1:0];
   endfunction

   function automatic logic [PosW-1:0] pos_sat(logic signed [AccPW-1:0] v);
      if (v > 23'sd1048575) begin
         return 21'h0FFFFF;
      end else if (v < -23'sd1048576) begin
         return 21'h100000;
      end
      return v[PosW-1:0];
   endfunction

   function automatic link_type make_link(trig_type t, twist_type tw,
                                          logic signed [LinkPW-1:0] px,
                                          logic signed [LinkPW-1:0] py,
                                          logic signed [LinkPW-1:0] pz);
      link_type                l;
      logic signed [TrigW-1:0] neg_s;
      logic signed [TrigW-1:0] neg_c;
      neg_s = -t.s;
      neg_c = -t.c;
      l.r[0] = t.c;
      l.r[1] = neg_s;
      l.r[2] = '0;
      unique case (tw)
         TWIST_NONE: begin
            l.r[3] = t.s;  l.r[4] = t.c;  l.r[5] = '0;
            l.r[6] = '0;   l.r[7] = '0;   l.r[8] = OneQ16;
         end
         TWIST_NEG: begin
            l.r[3] = '0;   l.r[4] = '0;   l.r[5] = -OneQ16;
            l.r[6] = t.s;  l.r[7] = t.c;  l.r[8] = '0;
         end
         default: begin
            l.r[3] = '0;    l.r[4] = '0;    l.r[5] = OneQ16;
            l.r[6] = neg_s; l.r[7] = neg_c; l.r[8] = '0;
         end
      endcase
      l.p[0] = px;
      l.p[1] = py;
      l.p[2] = pz;
      return l;
   endfunction

endpackage

/* rtl/fkin_fifo.sv */
// ----------------------------------------------------------------------------
// fkin_fifo
// Small synchronous queue with registered pointers and a fill count.
// ----------------------------------------------------------------------------
module fkin_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/fkin_front.sv */
// ----------------------------------------------------------------------------
// fkin_front
// Accepts joint words and turns each angle into cosine and sine through
// six parallel pipelined CORDIC lanes, one rotation step per stage.
// ----------------------------------------------------------------------------
module fkin_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  fkin_pkg::joint_angle_type in_angle,
   output logic                     out_valid,
   output fkin_pkg::joint_trig_type out_trig
);

   localparam int NJ = fkin_pkg::NumJoints;
   localparam int NS = fkin_pkg::CordicSteps;
   localparam int XW = fkin_pkg::XyW;
   localparam int ZW = fkin_pkg::ZW;

   logic signed [XW-1:0] x_ff [NJ][NS+1];
   logic signed [XW-1:0] x_in [NJ][NS+1];
   logic signed [XW-1:0] y_ff [NJ][NS+1];
   logic signed [XW-1:0] y_in [NJ][NS+1];
   logic signed [ZW-1:0] z_ff [NJ][NS+1];
   logic signed [ZW-1:0] z_in [NJ][NS+1];
   logic                 flip_ff [NJ][NS+1];
   logic                 flip_in [NJ][NS+1];
   logic [NS:0]          valid_ff, valid_in;
   fkin_pkg::joint_trig_type trig_ff, trig_in;
   logic                 out_valid_ff;

   always_comb begin
      logic signed [34:0] prod;
      logic [31:0]        ph;
      logic               fl;
      logic signed [ZW-1:0] at;
      for (int l = 0; l < NJ; l++) begin
         // angle to phase in 2^-32 turn, fold quadrants two and three
         prod = $signed(in_angle[l]) * $signed({1'b0, fkin_pkg::PhaseScale});
         ph   = prod[31:0];
         fl   = ph[31] ^ ph[30];
         x_in[l][0]    = fkin_pkg::CordicX0;
         y_in[l][0]    = '0;
         z_in[l][0]    = ZW'($signed({ph[31] ^ fl, ph[30:0]}));
         flip_in[l][0] = fl;
         for (int s = 0; s < NS; s++) begin
            at = ZW'({1'b0, fkin_pkg::AtanTurns[s]});
            flip_in[l][s+1] = flip_ff[l][s];
            if (z_ff[l][s] >= 0) begin
               x_in[l][s+1] = x_ff[l][s] - (y_ff[l][s] >>> s);
               y_in[l][s+1] = y_ff[l][s] + (x_ff[l][s] >>> s);
               z_in[l][s+1] = z_ff[l][s] - at;
            end else begin
               x_in[l][s+1] = x_ff[l][s] + (y_ff[l][s] >>> s);
               y_in[l][s+1] = y_ff[l][s] - (x_ff[l][s] >>> s);
               z_in[l][s+1] = z_ff[l][s] + at;
            end
         end
         trig_in[l].c = fkin_pkg::trig_round(x_ff[l][NS], flip_ff[l][NS]);
         trig_in[l].s = fkin_pkg::trig_round(y_ff[l][NS], flip_ff[l][NS]);
      end
      valid_in = {valid_ff[NS-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         flip_ff <= flip_in;
         trig_ff <= trig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[NS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_trig  = trig_ff;

endmodule

/* rtl/fkin_compose.sv */
// ----------------------------------------------------------------------------
// fkin_compose
// One link of the transform chain: acc * link, products in the first
// stage, sums with rounding in the second.
// ----------------------------------------------------------------------------
module fkin_compose (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  fkin_pkg::pose_type       in_acc,
   input  fkin_pkg::link_type       in_link,
   input  fkin_pkg::joint_trig_type in_trig,
   output logic                     out_valid,
   output fkin_pkg::pose_type       out_acc,
   output fkin_pkg::joint_trig_type out_trig
);

   localparam int PW  = fkin_pkg::ProdW;
   localparam int PPW = fkin_pkg::PProdW;
   localparam int SW  = fkin_pkg::SumW;
   localparam int AW  = fkin_pkg::AccPW;

   logic signed [PW-1:0]  prod_r_ff [9][3];
   logic signed [PW-1:0]  prod_r_in [9][3];
   logic signed [PPW-1:0] prod_p_ff [9];
   logic signed [PPW-1:0] prod_p_in [9];
   logic [2:0][AW-1:0]    accp_ff;
   fkin_pkg::joint_trig_type trig1_ff, trig2_ff;
   fkin_pkg::pose_type    acc_ff, acc_in;
   logic                  valid1_ff, valid2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               prod_r_in[i*3+j][k] = $signed(in_acc.r[i*3+k]) * $signed(in_link.r[k*3+j]);
            end
            prod_p_in[i*3+j] = $signed(in_acc.r[i*3+j]) * $signed(in_link.p[j]);
         end
      end
   end

   always_comb begin
      logic signed [SW-1:0] sum;
      for (int e = 0; e < 9; e++) begin
         sum = SW'(prod_r_ff[e][0]) + SW'(prod_r_ff[e][1]) + SW'(prod_r_ff[e][2]);
         acc_in.r[e] = fkin_pkg::rot_round(sum);
      end
      for (int i = 0; i < 3; i++) begin
         sum = SW'(prod_p_ff[i*3]) + SW'(prod_p_ff[i*3+1]) + SW'(prod_p_ff[i*3+2]);
         acc_in.p[i] = $signed(accp_ff[i]) + fkin_pkg::pos_round(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_r_ff <= prod_r_in;
         prod_p_ff <= prod_p_in;
         accp_ff   <= in_acc.p;
         trig1_ff  <= in_trig;
         acc_ff    <= acc_in;
         trig2_ff  <= trig1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_acc   = acc_ff;
   assign out_trig  = trig2_ff;

endmodule

/* rtl/fkin_back.sv */
// ----------------------------------------------------------------------------
// fkin_back
// Chains the five link products behind the first link's pose and
// saturates the final position.
// ----------------------------------------------------------------------------
module fkin_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  fkin_pkg::joint_trig_type in_trig,
   input  fkin_pkg::cfg_type        cfg,
   output logic                     out_valid,
   output fkin_pkg::result_type     out_result
);

   localparam int LW = fkin_pkg::LinkPW;
   localparam int AW = fkin_pkg::AccPW;

   fkin_pkg::pose_type       acc_w   [6];
   fkin_pkg::joint_trig_type trig_w  [6];
   logic                     valid_w [6];
   fkin_pkg::link_type       link_w  [6];
   logic signed [LW-1:0]     zero_p, base_p, ual_p, fal_p, third_p, fourth_p;
   logic signed [LW-1:0]     fifth_neg_p, sixth_p;

   assign zero_p      = '0;
   assign base_p      = LW'(cfg.base_height);
   assign ual_p       = LW'(cfg.upper_arm_length);
   assign fal_p       = LW'(cfg.forearm_length);
   assign third_p     = LW'(cfg.third_offset);
   assign fourth_p    = LW'(cfg.fourth_offset);
   assign fifth_neg_p = -LW'(cfg.fifth_offset);
   assign sixth_p     = LW'(cfg.sixth_offset);

   always_comb begin
      link_w[0] = fkin_pkg::make_link(in_trig[0], fkin_pkg::TWIST_NONE,
                                      zero_p, zero_p, base_p);
      acc_w[0].r = link_w[0].r;
      for (int i = 0; i < 3; i++) begin
         acc_w[0].p[i] = AW'($signed(link_w[0].p[i]));
      end
      trig_w[0]  = in_trig;
      valid_w[0] = in_valid;
      link_w[1] = fkin_pkg::make_link(trig_w[0][1], fkin_pkg::TWIST_NEG,
                                      zero_p, zero_p, zero_p);
      link_w[2] = fkin_pkg::make_link(trig_w[1][2], fkin_pkg::TWIST_NONE,
                                      ual_p, zero_p, third_p);
      link_w[3] = fkin_pkg::make_link(trig_w[2][3], fkin_pkg::TWIST_NONE,
                                      fal_p, zero_p, fourth_p);
      link_w[4] = fkin_pkg::make_link(trig_w[3][4], fkin_pkg::TWIST_NEG,
                                      zero_p, fifth_neg_p, zero_p);
      link_w[5] = fkin_pkg::make_link(trig_w[4][5], fkin_pkg::TWIST_LAST,
                                      zero_p, sixth_p, zero_p);
   end

   // trig_w[k] is the word entering link stage k, so stage k builds link k+1
   // from joint k+1 of that same word
   for (genvar k = 0; k < 5; k++) begin : g_link
      fkin_compose u_compose (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (k == 0 ? valid_w[0] : valid_w[k]),
         .in_acc    (acc_w[k]),
         .in_link   (link_w[k+1]),
         .in_trig   (trig_w[k]),
         .out_valid (valid_w[k+1]),
         .out_acc   (acc_w[k+1]),
         .out_trig  (trig_w[k+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_result.pos[i] = fkin_pkg::pos_sat($signed(acc_w[5].p[i]));
      end
      out_result.rot = acc_w[5].r;
   end

   assign out_valid = valid_w[5];

endmodule

/* rtl/forward_kinematics_6dof_core.sv */
// ----------------------------------------------------------------------------
// forward_kinematics_6dof_core
// Six-joint arm forward kinematics: joint angles in, 3x3 rotation and
// saturated position out.
// ----------------------------------------------------------------------------
// The core takes one joint word per clock while full is low and returns
// one pose word per joint word, in order. A front pipeline of 18 stages
// computes cosine and sine of all six angles (CORDIC steps, then rounding,
// six lanes side by side), a short queue decouples it from a back pipeline
// of 10 stages that multiplies the five link transforms (a product stage
// and a sum stage per link), and a result queue holds finished poses.
// Words pass these parts in that order; the sustained rate is one word per
// cycle while the result queue does not fill. full rises only when the
// middle queue is full; the back pipeline stalls only while the result
// queue is full. Registers are written through csr_we/csr_index/csr_wdata
// and must only change while no word is in flight; index 7 is ignored.
// ----------------------------------------------------------------------------
module forward_kinematics_6dof_core #(
   parameter int MID_DEPTH = fkin_pkg::MidDepth,
   parameter int OUT_DEPTH = fkin_pkg::OutDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic signed [15:0]  req_joint1_angle,
   input  logic signed [15:0]  req_joint2_angle,
   input  logic signed [15:0]  req_joint3_angle,
   input  logic signed [15:0]  req_joint4_angle,
   input  logic signed [15:0]  req_joint5_angle,
   input  logic signed [15:0]  req_joint6_angle,
   output logic                empty,
   input  logic                pop,
   output logic signed [20:0]  rsp_pos_x,
   output logic signed [20:0]  rsp_pos_y,
   output logic signed [20:0]  rsp_pos_z,
   output logic signed [17:0]  rsp_rot_00,
   output logic signed [17:0]  rsp_rot_01,
   output logic signed [17:0]  rsp_rot_02,
   output logic signed [17:0]  rsp_rot_10,
   output logic signed [17:0]  rsp_rot_11,
   output logic signed [17:0]  rsp_rot_12,
   output logic signed [17:0]  rsp_rot_20,
   output logic signed [17:0]  rsp_rot_21,
   output logic signed [17:0]  rsp_rot_22,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [17:0]         csr_wdata
);

   fkin_pkg::cfg_type        cfg_ff, cfg_in;
   fkin_pkg::joint_angle_type angles;
   fkin_pkg::joint_trig_type front_trig, mid_trig;
   fkin_pkg::result_type     back_result, out_result;
   logic                     front_en, front_valid;
   logic                     mid_full, mid_empty;
   logic                     back_en, back_valid;
   logic                     out_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            fkin_pkg::REG_BASE_HEIGHT:      cfg_in.base_height      = csr_wdata;
            fkin_pkg::REG_UPPER_ARM_LENGTH: cfg_in.upper_arm_length = csr_wdata;
            fkin_pkg::REG_FOREARM_LENGTH:   cfg_in.forearm_length   = csr_wdata;
            fkin_pkg::REG_THIRD_OFFSET:     cfg_in.third_offset     = csr_wdata;
            fkin_pkg::REG_FOURTH_OFFSET:    cfg_in.fourth_offset    = csr_wdata;
            fkin_pkg::REG_FIFTH_OFFSET:     cfg_in.fifth_offset     = csr_wdata;
            fkin_pkg::REG_SIXTH_OFFSET:     cfg_in.sixth_offset     = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign angles[0] = req_joint1_angle;
   assign angles[1] = req_joint2_angle;
   assign angles[2] = req_joint3_angle;
   assign angles[3] = req_joint4_angle;
   assign angles[4] = req_joint5_angle;
   assign angles[5] = req_joint6_angle;

   // whole front advances together; a full middle queue freezes it
   assign front_en = !mid_full;
   assign full     = mid_full;

   fkin_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (front_en),
      .in_valid  (push),
      .in_angle  (angles),
      .out_valid (front_valid),
      .out_trig  (front_trig)
   );

   fkin_fifo #(
      .WIDTH ($bits(fkin_pkg::joint_trig_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_en && front_valid),
      .wdata (front_trig),
      .full  (mid_full),
      .pop   (back_en),
      .rdata (mid_trig),
      .empty (mid_empty)
   );

   assign back_en = !out_full;

   fkin_back u_back (
      .clock      (clock),
      .reset      (reset),
      .enable     (back_en),
      .in_valid   (!mid_empty),
      .in_trig    (mid_trig),
      .cfg        (cfg_ff),
      .out_valid  (back_valid),
      .out_result (back_result)
   );

   fkin_fifo #(
      .WIDTH ($bits(fkin_pkg::result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (back_en && back_valid),
      .wdata (back_result),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_result),
      .empty (empty)
   );

   assign rsp_pos_x  = out_result.pos[0];
   assign rsp_pos_y  = out_result.pos[1];
   assign rsp_pos_z  = out_result.pos[2];
   assign rsp_rot_00 = out_result.rot[0];
   assign rsp_rot_01 = out_result.rot[1];
   assign rsp_rot_02 = out_result.rot[2];
   assign rsp_rot_10 = out_result.rot[3];
   assign rsp_rot_11 = out_result.rot[4];
   assign rsp_rot_12 = out_result.rot[5];
   assign rsp_rot_20 = out_result.rot[6];
   assign rsp_rot_21 = out_result.rot[7];
   assign rsp_rot_22 = out_result.rot[8];

endmodule
